// ===== sv/lru_pack_handle_cache_unit_assert.svh =====
// assertion macros for the pack handle cache checker
// no dependencies; included by the checker file
`ifndef LRU_PACK_HANDLE_CACHE_UNIT_ASSERT_SVH
`define LRU_PACK_HANDLE_CACHE_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LPC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lpc_pkg.sv =====
// shared types and constants for the pack handle cache
// no dependencies
package lpc_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int SLOT_W      = 3;
  localparam int DETAIL_W    = 2;
  localparam int BLOCK_W     = 16;
  localparam int TICK_W      = 32;

  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_FLUSH  = 1'b1
  } req_type_t;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_FILL    = 3'd1,
    ST_REPLACE = 3'd2,
    ST_FAIL    = 3'd3,
    ST_FLUSH   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [DETAIL_W-1:0] detail;
    logic [BLOCK_W-1:0]  block;
    logic [TICK_W-1:0]   tick;
  } entry_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [DETAIL_W-1:0] ev_detail;
    logic [BLOCK_W-1:0]  ev_block;
  } result_t;

endpackage

// ===== sv/lpc_if.sv =====
// valid/ready channels for requests and results of the pack handle cache
// depends on lpc_pkg
interface lpc_req_if import lpc_pkg::*; ();
  logic                valid;
  logic                ready;
  req_type_t           req_type;
  logic [DETAIL_W-1:0] detail_level;
  logic [BLOCK_W-1:0]  block_index;
  logic [TICK_W-1:0]   tick_time;
  logic                open_ok;

  modport source (output valid, req_type, detail_level, block_index, tick_time, open_ok,
                  input ready);
  modport sink   (input valid, req_type, detail_level, block_index, tick_time, open_ok,
                  output ready);
endinterface

interface lpc_rsp_if import lpc_pkg::*; ();
  logic                valid;
  logic                ready;
  status_t             status;
  logic [SLOT_W-1:0]   slot;
  logic [DETAIL_W-1:0] evicted_detail;
  logic [BLOCK_W-1:0]  evicted_block;

  modport source (output valid, status, slot, evicted_detail, evicted_block,
                  input ready);
  modport sink   (input valid, status, slot, evicted_detail, evicted_block,
                  output ready);
endinterface

// ===== sv/lpc_table.sv =====
// entry store of the pack handle cache: one write port, one registered read port
// depends on lpc_pkg
module lpc_table import lpc_pkg::*; #(
  parameter int  ENTRIES = ENTRIES_DEF,
  localparam int AW      = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/lpc_ctrl.sv =====
// sequencer of the pack handle cache: key search, oldest-entry scan, result register
// depends on lpc_pkg and lpc_if; drives the lpc_table ports
module lpc_ctrl import lpc_pkg::*; #(
  parameter int  ENTRIES = ENTRIES_DEF,
  localparam int AW      = $clog2(ENTRIES),
  localparam int CW      = $clog2(ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  lpc_req_if.sink       req,
  lpc_rsp_if.source     rsp,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output entry_t        wr_data,
  output logic [AW-1:0] rd_addr,
  input  entry_t        rd_data
);

  state_t              state, state_next;
  logic [DETAIL_W-1:0] key_detail;
  logic [BLOCK_W-1:0]  key_block;
  logic [TICK_W-1:0]   key_tick;
  logic                key_ok;
  logic [CW-1:0]       fill_count;
  logic [CW-1:0]       idx;
  logic [AW-1:0]       cmp_idx;
  logic                cmp_live;
  logic [AW-1:0]       best_idx;
  logic [TICK_W-1:0]   best_time;
  logic [DETAIL_W-1:0] best_detail;
  logic [BLOCK_W-1:0]  best_block;
  result_t             res;
  result_t             out_res;
  logic                out_valid;

  logic accept, out_free, issue, full, key_match, walk_done, older;

  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign issue     = idx < fill_count;
  assign full      = fill_count == CW'(ENTRIES);
  assign key_match = cmp_live && rd_data.detail == key_detail && rd_data.block == key_block;
  // the read is registered, so the walk ends once the last issued entry has been compared
  assign walk_done = !cmp_live && !issue;
  // first entry seeds the minimum, ties keep the lower slot
  assign older     = cmp_live && (cmp_idx == '0 || rd_data.tick < best_time);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req.req_type == REQ_FLUSH) ? S_RESULT : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (key_match) begin
          state_next = S_RESULT;
        end else if (walk_done) begin
          state_next = (key_ok && full) ? S_SCAN : S_RESULT;
        end
      end
      S_SCAN: begin
        if (walk_done) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready       = state == S_IDLE;
    rd_addr         = idx[AW-1:0];
    wr_en           = 1'b0;
    wr_addr         = cmp_idx;
    wr_data.detail  = key_detail;
    wr_data.block   = key_block;
    wr_data.tick    = key_tick;
    case (state)
      S_SEARCH: begin
        if (key_match) begin
          wr_en = 1'b1;
        end else if (walk_done && key_ok && !full) begin
          wr_en   = 1'b1;
          wr_addr = fill_count[AW-1:0];
        end
      end
      S_SCAN: begin
        if (walk_done) begin
          wr_en   = 1'b1;
          wr_addr = best_idx;
        end
      end
      default: wr_en = 1'b0;
    endcase
    rsp.valid          = out_valid;
    rsp.status         = out_res.status;
    rsp.slot           = out_res.slot;
    rsp.evicted_detail = out_res.ev_detail;
    rsp.evicted_block  = out_res.ev_block;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      cmp_live   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            key_detail <= req.detail_level;
            key_block  <= req.block_index;
            key_tick   <= req.tick_time;
            key_ok     <= req.open_ok;
            idx        <= '0;
            cmp_live   <= 1'b0;
            if (req.req_type == REQ_FLUSH) begin
              fill_count <= '0;
              res        <= '{status: ST_FLUSH, slot: '0, ev_detail: '0, ev_block: '0};
            end
          end
        end
        S_SEARCH, S_SCAN: begin
          cmp_live <= issue;
          cmp_idx  <= idx[AW-1:0];
          if (issue) begin
            idx <= idx + CW'(1);
          end
          if (state == S_SEARCH) begin
            if (key_match) begin
              res <= '{status: ST_HIT, slot: SLOT_W'(cmp_idx), ev_detail: '0, ev_block: '0};
            end else if (walk_done) begin
              if (!key_ok) begin
                res <= '{status: ST_FAIL, slot: '0, ev_detail: '0, ev_block: '0};
              end else if (!full) begin
                res <= '{status: ST_FILL, slot: SLOT_W'(fill_count), ev_detail: '0,
                         ev_block: '0};
                fill_count <= fill_count + CW'(1);
              end else begin
                idx      <= '0;
                cmp_live <= 1'b0;
              end
            end
          end else begin
            if (older) begin
              best_idx    <= cmp_idx;
              best_time   <= rd_data.tick;
              best_detail <= rd_data.detail;
              best_block  <= rd_data.block;
            end
            if (walk_done) begin
              res <= '{status: ST_REPLACE, slot: SLOT_W'(best_idx), ev_detail: best_detail,
                       ev_block: best_block};
            end
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_res   <= res;
            out_valid <= 1'b1;
          end
        end
        default: cmp_live <= 1'b0;
      endcase
    end
  end

endmodule

// ===== sv/lru_pack_handle_cache_unit.sv =====
// pack handle cache: one request at a time; a flush goes from accept to the result state;
// a lookup walks the filled slots in order and stops on a hit; a miss that may open on a
// full table then scans every slot and replaces the oldest entry; one table read per cycle sets
// the pace of each walk; ready is low from accept until the result is loaded into the output register
// synchronous reset empties the table (fill count zero) and clears the output valid flag
// depends on lpc_pkg, lpc_if, lpc_table, lpc_ctrl
module lru_pack_handle_cache_unit import lpc_pkg::*; #(
  parameter int  ENTRIES = ENTRIES_DEF,
  localparam int AW      = $clog2(ENTRIES)
) (
  input  logic      clk,
  input  logic      rst,
  lpc_req_if.sink   req,
  lpc_rsp_if.source rsp
);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;

  lpc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lpc_table #(.ENTRIES(ENTRIES)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== sv/lpc_chk.sv =====
// port-level checks for the pack handle cache, bound to the top level
// depends on lpc_pkg and lru_pack_handle_cache_unit_assert.svh
`include "lru_pack_handle_cache_unit_assert.svh"

module lpc_chk import lpc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input status_t             out_status,
  input logic [SLOT_W-1:0]   out_slot,
  input logic [DETAIL_W-1:0] out_ev_detail,
  input logic [BLOCK_W-1:0]  out_ev_block
);

  `LPC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "ready high right after a transaction")
  `LPC_ASSERT_NEXT(a_out_held, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `LPC_ASSERT_SAME(a_evict_zero, clk, rst, out_valid && out_status != ST_REPLACE, out_ev_detail == '0 && out_ev_block == '0, "evicted key set without a replacement")
  `LPC_ASSERT_SAME(a_slot_zero, clk, rst, out_valid && (out_status == ST_FAIL || out_status == ST_FLUSH), out_slot == '0, "slot set on a failed open or flush")

endmodule

bind lru_pack_handle_cache_unit lpc_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (req.valid),
  .in_ready      (req.ready),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .out_status    (rsp.status),
  .out_slot      (rsp.slot),
  .out_ev_detail (rsp.evicted_detail),
  .out_ev_block  (rsp.evicted_block)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for the pack handle cache: lookups, fills, oldest-entry replacement
// and flushes, checked against an in-bench table model
// depends on lpc_pkg, lpc_if and the lru_pack_handle_cache_unit rtl
module testbench;
  import lpc_pkg::*;

  localparam int N_SLOTS     = ENTRIES_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 120;
  localparam int N_ITEMS     = 550;

  typedef struct {
    req_type_t           req_type;
    logic [DETAIL_W-1:0] detail;
    logic [BLOCK_W-1:0]  block;
    logic [TICK_W-1:0]   tick;
    logic                open_ok;
    int unsigned         gap;
    bit                  drain;
  } pack_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lpc_req_if req_ch ();
  lpc_rsp_if rsp_ch ();

  lru_pack_handle_cache_unit #(.ENTRIES(N_SLOTS)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // handle table as the bench sees it
  bit                  tbl_valid  [N_SLOTS];
  logic [DETAIL_W-1:0] tbl_detail [N_SLOTS];
  logic [BLOCK_W-1:0]  tbl_block  [N_SLOTS];
  logic [TICK_W-1:0]   tbl_tick   [N_SLOTS];
  int unsigned         tbl_fill;

  pack_req_t   pending_q[$];
  result_t     expected_q[$];
  pack_req_t   cur_req;
  int unsigned status_seen [5];
  int unsigned errors;
  int unsigned results_checked;
  int unsigned requests_sent;
  int unsigned idle_run;
  int unsigned quiet_cycles;

  function automatic result_t lookup_handle(input pack_req_t r);
    result_t           res;
    int unsigned       victim;
    logic [TICK_W-1:0] oldest;
    bit                found;
    res        = '0;
    res.status = ST_HIT;
    found      = 1'b0;
    if (r.req_type == REQ_FLUSH) begin
      for (int i = 0; i < N_SLOTS; i++) tbl_valid[i] = 1'b0;
      tbl_fill   = 0;
      res.status = ST_FLUSH;
    end else begin
      for (int i = 0; i < N_SLOTS; i++) begin
        if (!found && i < tbl_fill && tbl_valid[i] &&
            tbl_detail[i] == r.detail && tbl_block[i] == r.block) begin
          tbl_tick[i] = r.tick;
          res.slot    = SLOT_W'(i);
          found       = 1'b1;
        end
      end
      if (found) begin
        res.status = ST_HIT;
      end else if (!r.open_ok) begin
        res.status = ST_FAIL;
      end else if (tbl_fill < N_SLOTS) begin
        res.status           = ST_FILL;
        res.slot             = SLOT_W'(tbl_fill);
        tbl_valid[tbl_fill]  = 1'b1;
        tbl_detail[tbl_fill] = r.detail;
        tbl_block[tbl_fill]  = r.block;
        tbl_tick[tbl_fill]   = r.tick;
        tbl_fill++;
      end else begin
        // strict less-than keeps the lowest slot on equal access times
        victim = 0;
        oldest = tbl_tick[0];
        for (int i = 1; i < N_SLOTS; i++) begin
          if (tbl_valid[i] && tbl_tick[i] < oldest) begin
            victim = i;
            oldest = tbl_tick[i];
          end
        end
        res.status         = ST_REPLACE;
        res.slot           = SLOT_W'(victim);
        res.ev_detail      = tbl_detail[victim];
        res.ev_block       = tbl_block[victim];
        tbl_detail[victim] = r.detail;
        tbl_block[victim]  = r.block;
        tbl_tick[victim]   = r.tick;
      end
    end
    status_seen[res.status]++;
    return res;
  endfunction

  task automatic queue_req(input req_type_t rt, input logic [DETAIL_W-1:0] det,
                           input logic [BLOCK_W-1:0] blk, input logic [TICK_W-1:0] tk,
                           input logic ok, input int unsigned gap, input bit drain);
    pack_req_t r;
    r.req_type = rt;
    r.detail   = det;
    r.block    = blk;
    r.tick     = tk;
    r.open_ok  = ok;
    r.gap      = gap;
    r.drain    = drain;
    pending_q.push_back(r);
  endtask

  function automatic int unsigned draw_gap(input bit no_gaps);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_LOOKUP;
    req_ch.detail_level = '0;
    req_ch.block_index  = '0;
    req_ch.tick_time    = '0;
    req_ch.open_ok      = 1'b0;
    rsp_ch.ready        = 1'b0;
  end

  // request driver: presents queued transactions, honoring per-item gaps and drain points
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      idle_run     <= 0;
      tbl_fill     = 0;
      for (int i = 0; i < N_SLOTS; i++) tbl_valid[i] = 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_q.push_back(lookup_handle(cur_req));
        requests_sent++;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the offered transaction
      end else if (pending_q.size() != 0 && idle_run >= pending_q[0].gap &&
                   (!pending_q[0].drain || expected_q.size() == 0)) begin
        cur_req              = pending_q.pop_front();
        req_ch.req_type     <= cur_req.req_type;
        req_ch.detail_level <= cur_req.detail;
        req_ch.block_index  <= cur_req.block;
        req_ch.tick_time    <= cur_req.tick;
        req_ch.open_ok      <= cur_req.open_ok;
        req_ch.valid        <= 1'b1;
        idle_run            <= 0;
      end else begin
        req_ch.valid <= 1'b0;
        idle_run     <= idle_run + 1;
      end
    end
  end

  // result side back-pressure
  int unsigned rsp_taken;
  int unsigned stall_left;
  bit          hold_done;
  int unsigned pick;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_taken    <= 0;
      stall_left   <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) rsp_taken <= rsp_taken + 1;
      if (!hold_done && rsp_taken >= HOLD_AT) begin
        // one long hold-off so the block backs up and stalls its input
        hold_done    <= 1'b1;
        stall_left   <= HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if ((rsp_taken / 50) % 3 == 0) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          rsp_ch.ready <= 1'b1;
        end else if (pick < 95) begin
          stall_left   <= $urandom_range(0, 2);
          rsp_ch.ready <= 1'b0;
        end else begin
          stall_left   <= $urandom_range(9, 39);
          rsp_ch.ready <= 1'b0;
        end
      end
    end
  end

  // result monitor
  result_t got;
  result_t want;

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status    = rsp_ch.status;
      got.slot      = rsp_ch.slot;
      got.ev_detail = rsp_ch.evicted_detail;
      got.ev_block  = rsp_ch.evicted_block;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected result: status %0d slot %0d evicted %0d/%h",
                   $realtime, got.status, got.slot, got.ev_detail, got.ev_block);
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] result %0d mismatch: expected status %0d slot %0d evicted %0d/%h,%s",
                     $realtime, results_checked, want.status, want.slot, want.ev_detail,
                     want.ev_block, $sformatf(" got status %0d slot %0d evicted %0d/%h",
                     got.status, got.slot, got.ev_detail, got.ev_block));
        end
      end
    end
  end

  // cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    logic [TICK_W-1:0]   tick_now;
    logic [DETAIL_W-1:0] key_det [16];
    logic [BLOCK_W-1:0]  key_blk [16];
    int unsigned         seg_kind;
    int unsigned         seg_len;
    int unsigned         n_keys;
    int unsigned         k;
    bit                  no_gaps;
    bit                  drain_first;

    errors          = 0;
    results_checked = 0;
    requests_sent   = 0;
    quiet_cycles    = 0;
    tbl_fill        = 0;

    // directed: flush when empty, failed open, fill all slots with extreme keys and ticks
    queue_req(REQ_FLUSH,  2'd3, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd0, 16'h0000, 32'd5,         1'b0, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd0, 16'h0000, 32'd100,       1'b1, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd3, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd1, 16'h5555, 32'd0,         1'b1, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd2, 16'hAAAA, 32'd50,        1'b1, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd0, 16'h0001, 32'd60,        1'b1, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd3, 16'h0000, 32'd50,        1'b1, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd0, 16'hFFFF, 32'd200,       1'b1, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd1, 16'h8000, 32'd300,       1'b1, 0, 1'b0);
    // hits on the last and first slot; a hit ignores open_ok
    queue_req(REQ_LOOKUP, 2'd1, 16'h8000, 32'd400,       1'b0, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd0, 16'h0000, 32'd400,       1'b1, 0, 1'b0);
    // same block, other detail level: a miss, and the open fails
    queue_req(REQ_LOOKUP, 2'd0, 16'h5555, 32'd450,       1'b0, 0, 1'b0);
    // replacements: zero tick first, then a tie between two slots
    queue_req(REQ_LOOKUP, 2'd2, 16'h1234, 32'd500,       1'b1, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd3, 16'h4321, 32'd600,       1'b1, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd2, 16'hAAAA, 32'd700,       1'b1, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd3, 16'hFFFF, 32'd0,         1'b1, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd1, 16'h5555, 32'd800,       1'b1, 0, 1'b0);
    // flush a full table, then refill
    queue_req(REQ_FLUSH,  2'd0, 16'h0000, 32'd0,         1'b1, 5, 1'b1);
    queue_req(REQ_LOOKUP, 2'd0, 16'h0000, 32'd900,       1'b1, 0, 1'b0);
    queue_req(REQ_LOOKUP, 2'd3, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 0, 1'b0);

    tick_now = 32'd1000;
    while (pending_q.size() < N_ITEMS) begin
      seg_kind    = $urandom_range(0, 99);
      no_gaps     = ($urandom_range(0, 3) == 0);
      drain_first = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) tick_now = 32'hFFFF_FFF0;
      if (seg_kind < 75) begin
        // working set of keys revisited with advancing ticks
        n_keys = $urandom_range(3, 14);
        for (int i = 0; i < n_keys; i++) begin
          key_det[i] = 2'($urandom_range(0, 3));
          key_blk[i] = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 7));
        end
        seg_len = $urandom_range(10, 40);
        if ($urandom_range(0, 1))
          queue_req(REQ_FLUSH, 2'($urandom), 16'($urandom), $urandom, 1'($urandom),
                    draw_gap(no_gaps), drain_first);
        for (int i = 0; i < seg_len; i++) begin
          k        = $urandom_range(0, n_keys - 1);
          tick_now = tick_now + $urandom_range(0, 3);
          queue_req(REQ_LOOKUP, key_det[k], key_blk[k], tick_now,
                    ($urandom_range(0, 9) != 0), draw_gap(no_gaps), 1'b0);
        end
      end else if (seg_kind < 90) begin
        seg_len = $urandom_range(5, 15);
        for (int i = 0; i < seg_len; i++)
          queue_req(($urandom_range(0, 7) == 0) ? REQ_FLUSH : REQ_LOOKUP,
                    2'($urandom), 16'($urandom), $urandom, 1'($urandom),
                    draw_gap(no_gaps), drain_first && i == 0);
      end else begin
        // scattered ticks, extremes, mostly failing opens
        seg_len = $urandom_range(5, 15);
        for (int i = 0; i < seg_len; i++)
          queue_req(REQ_LOOKUP, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 7)),
                    ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF :
                    ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom,
                    ($urandom_range(0, 3) == 0), draw_gap(no_gaps), drain_first && i == 0);
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (!(pending_q.size() == 0 && !req_ch.valid && expected_q.size() == 0) &&
           quiet_cycles < STALL_LIMIT)
      @(negedge clk);

    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d cycles without a transaction, %0d results outstanding",
               quiet_cycles, expected_q.size());
      $display("FAILURE");
    end else begin
      repeat (DRAIN_WAIT) @(posedge clk);
      if (expected_q.size() != 0) errors++;
      $display("%0d requests, %0d results checked: %0d hits, %0d fills, %0d replacements,",
               requests_sent, results_checked, status_seen[ST_HIT], status_seen[ST_FILL],
               status_seen[ST_REPLACE]);
      $display("%0d failed opens, %0d flushes; %0d mismatches",
               status_seen[ST_FAIL], status_seen[ST_FLUSH], errors);
      if (errors == 0)
        $display("SUCCESS");
      else
        $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/lpc_pkg.sv
sv/lpc_if.sv
sv/lpc_table.sv
sv/lpc_ctrl.sv
sv/lru_pack_handle_cache_unit.sv
sv/lpc_chk.sv
tb/testbench.sv
